### hw/rtl/lcg_uniform_normal_generator_unit_assert.svh
// Assertion macros used by the checker file of the generator.
`ifndef LCG_UNIFORM_NORMAL_GENERATOR_UNIT_ASSERT_SVH
`define LCG_UNIFORM_NORMAL_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and idle during reset.
`define LUNG_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and idle during reset.
`define LUNG_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/lung_pkg.sv
// Types, codes and derived constants of the seed generator.
package lung_pkg;

	localparam int OP_W     = 2;
	localparam int STREAM_W = 4;
	localparam int SEED_W   = 35;
	localparam int VALUE_W  = 36;

	localparam int STREAMS      = 16;
	localparam int NORMAL_TERMS = 101;

	localparam int IDX_W  = (STREAMS > 1) ? $clog2(STREAMS) : 1;
	localparam int TERM_W = $clog2(NORMAL_TERMS);

	typedef enum logic [OP_W-1:0] {
		OP_UNIFORM = 2'd0,
		OP_NORMAL  = 2'd1,
		OP_LOAD    = 2'd2
	} op_t;

	// Integer square root, used only at elaboration.
	function automatic longint unsigned isqrt(input longint unsigned v);
		longint unsigned r;
		longint unsigned t;
		r = 0;
		for (int i = 31; i >= 0; i--) begin
			t = r | (64'd1 << i);
			if (t * t <= v)
				r = t;
		end
		return r;
	endfunction

	localparam int SCALE_BITS = 18;
	localparam longint unsigned K_VAL =
		isqrt((64'd12 << (2 * SCALE_BITS)) / NORMAL_TERMS);
	localparam int K_W = $clog2(K_VAL + 1);
	localparam logic [K_W-1:0] SCALE_K = K_W'(K_VAL);

	// Sum of the uniforms, centered deviation and product split.
	localparam int SUM_W   = SEED_W + $clog2(NORMAL_TERMS);
	localparam int D_W     = SUM_W + 1;
	localparam int D_LO_W  = 22;
	localparam int D_HI_W  = D_W - D_LO_W;
	localparam int PROD_W  = D_LO_W + K_W + 2;
	localparam int ACC_W   = D_W + K_W + 1;
	localparam int QF_W    = ACC_W - 1 - SCALE_BITS;

	localparam logic [SUM_W-1:0] OFFSET = SUM_W'(NORMAL_TERMS) << (SEED_W - 1);
	localparam logic signed [ACC_W-1:0] BIAS = ACC_W'(3) << (SEED_W + SCALE_BITS);

	// Division of the scaled value by six, four quotient bits per cycle.
	localparam int DIVISOR    = 6;
	localparam int REM_W      = 3;
	localparam int Q_W        = SEED_W + 3;
	localparam int DIV_STEP   = 4;
	localparam int DIV_CYCLES = (Q_W + DIV_STEP - 1) / DIV_STEP;
	localparam int DIV_W      = DIV_CYCLES * DIV_STEP;
	localparam logic [Q_W-1:0] LIMIT = Q_W'(DIVISOR) << SEED_W;

	localparam logic [VALUE_W-1:0] ONE_Q35 = VALUE_W'(1) << SEED_W;

	typedef struct packed {
		logic cap;
		logic load_wr;
		logic step;
		logic wb;
		logic center;
		logic mul_lo;
		logic mul_hi;
		logic mul_add;
		logic prep;
		logic div;
		logic normal;
		logic fin_load;
	} lung_ctl_t;

endpackage

### hw/rtl/lung_seed_table.sv
// Per-stream seed storage, every entry reset to one.
module lung_seed_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [lung_pkg::IDX_W-1:0]  wr_addr,
	input  logic [lung_pkg::SEED_W-1:0] wr_data,
	input  logic [lung_pkg::IDX_W-1:0]  rd_addr,
	output logic [lung_pkg::SEED_W-1:0] rd_data
);

	logic [lung_pkg::SEED_W-1:0] mem_q [lung_pkg::STREAMS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lung_pkg::STREAMS; i++)
				mem_q[i] <= lung_pkg::SEED_W'(1);
		end else if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	assign rd_data = mem_q[rd_addr];

endmodule

### hw/rtl/lung_ctrl.sv
// Sequencer that steps the shared generator, multiplier and divider.
module lung_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [lung_pkg::OP_W-1:0]     op,
	input  logic [lung_pkg::STREAM_W-1:0] stream,
	input  logic                          out_busy,
	output logic                          in_ready,
	output lung_pkg::lung_ctl_t           ctl
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_STEP,
		ST_CENTER,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_MUL_ADD,
		ST_PREP,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t                      state_q;
	logic [lung_pkg::TERM_W-1:0] cnt_q;
	logic                        normal_q;

	logic in_range;
	logic is_draw;
	logic last_step;
	logic last_div;

	assign in_range  = 32'(stream) < 32'(lung_pkg::STREAMS);
	assign is_draw   = in_range && (op == lung_pkg::OP_UNIFORM || op == lung_pkg::OP_NORMAL);
	assign last_step = !normal_q || (cnt_q == lung_pkg::TERM_W'(lung_pkg::NORMAL_TERMS - 1));
	assign last_div  = cnt_q == lung_pkg::TERM_W'(lung_pkg::DIV_CYCLES - 1);
	assign in_ready  = state_q == ST_IDLE;

	always_comb begin
		ctl        = '0;
		ctl.normal = normal_q;
		case (state_q)
			ST_IDLE: begin
				ctl.cap     = in_valid && is_draw;
				ctl.load_wr = in_valid && in_range && op == lung_pkg::OP_LOAD;
			end
			ST_STEP: begin
				ctl.step = 1'b1;
				ctl.wb   = last_step;
			end
			ST_CENTER:  ctl.center   = 1'b1;
			ST_MUL_LO:  ctl.mul_lo   = 1'b1;
			ST_MUL_HI:  ctl.mul_hi   = 1'b1;
			ST_MUL_ADD: ctl.mul_add  = 1'b1;
			ST_PREP:    ctl.prep     = 1'b1;
			ST_DIV:     ctl.div      = 1'b1;
			ST_FIN:     ctl.fin_load = !out_busy;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			normal_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid && is_draw) begin
						state_q  <= ST_STEP;
						cnt_q    <= '0;
						normal_q <= op == lung_pkg::OP_NORMAL;
					end
				end
				ST_STEP: begin
					cnt_q <= cnt_q + 1'b1;
					if (last_step)
						state_q <= normal_q ? ST_CENTER : ST_FIN;
				end
				ST_CENTER:  state_q <= ST_MUL_LO;
				ST_MUL_LO:  state_q <= ST_MUL_HI;
				ST_MUL_HI:  state_q <= ST_MUL_ADD;
				ST_MUL_ADD: state_q <= ST_PREP;
				ST_PREP: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (last_div)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!out_busy)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### hw/rtl/lung_datapath.sv
// Generator step, sum, shared multiplier and radix-16 divide-by-six unit.
module lung_datapath (
	input  logic                           clk,
	input  lung_pkg::lung_ctl_t            ctl,
	input  logic [lung_pkg::STREAM_W-1:0]  stream,
	input  logic [lung_pkg::SEED_W-1:0]    seed_value,
	input  logic [lung_pkg::SEED_W-1:0]    rd_data,
	output logic                           wr_en,
	output logic [lung_pkg::IDX_W-1:0]     wr_addr,
	output logic [lung_pkg::SEED_W-1:0]    wr_data,
	output logic [lung_pkg::IDX_W-1:0]     rd_addr,
	output logic [lung_pkg::VALUE_W-1:0]   res_value,
	output logic [lung_pkg::STREAM_W-1:0]  res_stream
);

	localparam int SEED_W = lung_pkg::SEED_W;
	localparam int SUM_W  = lung_pkg::SUM_W;
	localparam int D_W    = lung_pkg::D_W;
	localparam int D_LO_W = lung_pkg::D_LO_W;
	localparam int D_HI_W = lung_pkg::D_HI_W;
	localparam int K_W    = lung_pkg::K_W;
	localparam int PROD_W = lung_pkg::PROD_W;
	localparam int ACC_W  = lung_pkg::ACC_W;
	localparam int QF_W   = lung_pkg::QF_W;
	localparam int Q_W    = lung_pkg::Q_W;
	localparam int DIV_W  = lung_pkg::DIV_W;
	localparam int STEP   = lung_pkg::DIV_STEP;
	localparam int REM_W  = lung_pkg::REM_W;

	logic [lung_pkg::STREAM_W-1:0] stream_q;
	logic [SEED_W-1:0]             cur_seed_q;
	logic [SUM_W-1:0]              sum_q;
	logic signed [D_W-1:0]         d_q;
	logic signed [PROD_W-1:0]      prod_q;
	logic signed [ACC_W-1:0]       acc_q;
	logic [DIV_W-1:0]              dvd_q;
	logic [REM_W-1:0]              rem_q;
	logic [SEED_W-1:0]             quot_q;
	logic                          zero_q;
	logic                          clamp_q;

	logic [SEED_W-1:0]        seed_next;
	logic signed [D_LO_W:0]   mul_a;
	logic signed [K_W:0]      k_s;
	logic signed [PROD_W-1:0] mul_p;
	logic signed [ACC_W-1:0]  prod_ext;
	logic                     acc_pos;
	logic [QF_W-1:0]          q_scaled;
	logic [REM_W-1:0]         rem_n;
	logic [REM_W:0]           trial;
	logic [STEP-1:0]          qbits;

	// Multiply by five modulo 2^35 is a shift and an add.
	assign seed_next = (cur_seed_q << 2) + cur_seed_q;

	assign rd_addr = lung_pkg::IDX_W'(stream);
	assign wr_en   = ctl.load_wr || ctl.wb;
	assign wr_addr = ctl.load_wr ? lung_pkg::IDX_W'(stream) : lung_pkg::IDX_W'(stream_q);
	assign wr_data = ctl.load_wr ? (seed_value | SEED_W'(1)) : seed_next;

	// One multiplier serves both halves of the deviation.
	assign mul_a = ctl.mul_lo ? $signed({1'b0, d_q[D_LO_W-1:0]})
		: $signed({{(D_LO_W + 1 - D_HI_W){d_q[D_W-1]}}, d_q[D_W-1:D_LO_W]});
	assign k_s      = $signed({1'b0, lung_pkg::SCALE_K});
	assign mul_p    = mul_a * k_s;
	assign prod_ext = {{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};

	assign acc_pos  = !acc_q[ACC_W-1] && (acc_q != '0);
	assign q_scaled = acc_q[ACC_W-2:lung_pkg::SCALE_BITS];

	// Four restoring steps of the division by six.
	always_comb begin
		rem_n = rem_q;
		trial = '0;
		qbits = '0;
		for (int i = 0; i < STEP; i++) begin
			trial = {rem_n, dvd_q[DIV_W-1-i]};
			if (trial >= (REM_W + 1)'(lung_pkg::DIVISOR)) begin
				trial           = trial - (REM_W + 1)'(lung_pkg::DIVISOR);
				qbits[STEP-1-i] = 1'b1;
			end
			rem_n = trial[REM_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.cap) begin
			stream_q   <= stream;
			cur_seed_q <= rd_data;
			sum_q      <= '0;
		end
		if (ctl.step) begin
			cur_seed_q <= seed_next;
			sum_q      <= sum_q + SUM_W'(seed_next);
		end
		if (ctl.center)
			d_q <= $signed({1'b0, sum_q}) - $signed({1'b0, lung_pkg::OFFSET});
		if (ctl.mul_lo)
			prod_q <= mul_p;
		if (ctl.mul_hi) begin
			acc_q  <= prod_ext + lung_pkg::BIAS;
			prod_q <= mul_p;
		end
		if (ctl.mul_add)
			acc_q <= acc_q + (prod_ext <<< D_LO_W);
		if (ctl.prep) begin
			zero_q  <= !acc_pos;
			clamp_q <= acc_pos && (q_scaled >= QF_W'(lung_pkg::LIMIT));
			dvd_q   <= DIV_W'(q_scaled[Q_W-1:0]);
			rem_q   <= '0;
			quot_q  <= '0;
		end
		if (ctl.div) begin
			dvd_q  <= dvd_q << STEP;
			rem_q  <= rem_n;
			quot_q <= {quot_q[SEED_W-1-STEP:0], qbits};
		end
	end

	always_comb begin
		if (!ctl.normal)
			res_value = {1'b0, cur_seed_q};
		else if (zero_q)
			res_value = '0;
		else if (clamp_q)
			res_value = lung_pkg::ONE_Q35;
		else
			res_value = {1'b0, quot_q};
	end

	assign res_stream = stream_q;

endmodule

### hw/rtl/lcg_uniform_normal_generator_unit.sv
// Top level of the multi-stream uniform and normal random generator.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------
//  in      | input     | in_valid / in_ready  | op, stream, seed_value
//  out     | output    | out_valid/ out_ready | value, stream_echo
//
// A load, an unused op or an out-of-range stream gives no item; the block stays idle.
// A uniform draw runs through accept, one generator step and result load.
// A normal draw runs through accept, 101 steps of the shared multiply-by-five
// and accumulate unit, centering and scaling through one multiplier (center,
// low product, high product, add, prep), the divide-by-six unit and the result load.
// Reset sets every seed to one at once; a full output register stalls the last cycle.
module lcg_uniform_normal_generator_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [lung_pkg::OP_W-1:0]      op,
	input  logic [lung_pkg::STREAM_W-1:0]  stream,
	input  logic [lung_pkg::SEED_W-1:0]    seed_value,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [lung_pkg::VALUE_W-1:0]   value,
	output logic [lung_pkg::STREAM_W-1:0]  stream_echo
);

	lung_pkg::lung_ctl_t ctl;

	logic                          out_valid_q;
	logic [lung_pkg::VALUE_W-1:0]  value_q;
	logic [lung_pkg::STREAM_W-1:0] stream_echo_q;

	logic                          out_busy;
	logic                          wr_en;
	logic [lung_pkg::IDX_W-1:0]    wr_addr;
	logic [lung_pkg::SEED_W-1:0]   wr_data;
	logic [lung_pkg::IDX_W-1:0]    rd_addr;
	logic [lung_pkg::SEED_W-1:0]   rd_data;
	logic [lung_pkg::VALUE_W-1:0]  res_value;
	logic [lung_pkg::STREAM_W-1:0] res_stream;

	assign out_busy = out_valid_q && !out_ready;

	lung_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.op       (op),
		.stream   (stream),
		.out_busy (out_busy),
		.in_ready (in_ready),
		.ctl      (ctl)
	);

	lung_seed_table u_seed_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	lung_datapath u_datapath (
		.clk        (clk),
		.ctl        (ctl),
		.stream     (stream),
		.seed_value (seed_value),
		.rd_data    (rd_data),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.rd_addr    (rd_addr),
		.res_value  (res_value),
		.res_stream (res_stream)
	);

	// Output register: holds a finished item until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= ctl.fin_load || out_busy;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.fin_load) begin
			value_q       <= res_value;
			stream_echo_q <= res_stream;
		end
	end

	assign out_valid   = out_valid_q;
	assign value       = value_q;
	assign stream_echo = stream_echo_q;

endmodule

### hw/rtl/lung_checker.sv
// Port-level checks of the generator, bound to its top level.
`include "lcg_uniform_normal_generator_unit_assert.svh"

module lung_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic [lung_pkg::OP_W-1:0]      op,
	input logic [lung_pkg::STREAM_W-1:0]  stream,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [lung_pkg::VALUE_W-1:0]   value,
	input logic [lung_pkg::STREAM_W-1:0]  stream_echo
);

	// A waiting item must hold its payload.
	`LUNG_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(value) && $stable(stream_echo), "stalled output item changed")

	// No draw may exceed one in Q1.35.
	`LUNG_ASSERT_IMP(a_value_range, out_valid, value <= lung_pkg::ONE_Q35, "draw above one")

	// An accepted draw keeps the block busy for at least the next cycle.
	`LUNG_ASSERT_NXT(a_draw_busy, in_valid && in_ready && 32'(stream) < 32'(lung_pkg::STREAMS) && (op == lung_pkg::OP_UNIFORM || op == lung_pkg::OP_NORMAL), !in_ready, "ready right after a draw was accepted")

	// A new result only follows a cycle in which the block was busy.
	`LUNG_ASSERT_IMP(a_result_after_busy, $rose(out_valid), !$past(in_ready), "result appeared without work")

endmodule

bind lcg_uniform_normal_generator_unit lung_checker u_lung_checker (.*);
